/* sv/dhfk_pkg.sv */
// Package with shared types, constants and arithmetic helpers of the DH chain.
`timescale 1ns / 1ps
`default_nettype none
package dhfk_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int ROT_FRAC_BITS = 29;
    localparam int CORDIC_STEPS  = 28;
    localparam int ACC_W         = 66;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [31:0] ONE_ROT     = 32'sd1 <<< ROT_FRAC_BITS;

    typedef logic signed [31:0] data32_t;

    typedef enum logic [2:0] {
        DST_LR,
        DST_LRN,
        DST_LT,
        DST_ROT,
        DST_TRN
    } dst_kind_t;

    typedef struct packed {
        logic      start;
        logic      last;
        logic      rnd;
        dst_kind_t kind;
        logic [3:0] idx;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SC_T,
        S_SC_A,
        S_LINK,
        S_DRAIN1,
        S_MAT,
        S_DRAIN2,
        S_OUT
    } seq_state_t;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            unique case (i)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10679838;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670163;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                5'd24: r = 34'sd41;
                5'd25: r = 34'sd20;
                5'd26: r = 34'sd10;
                5'd27: r = 34'sd5;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic data32_t sat32(input logic signed [ACC_W-1:0] v);
        data32_t r;
        begin
            if (v > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}}))
                r = 32'sh7fffffff;
            else if (v < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}}))
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* sv/dhfk_if.sv */
// Valid/ready channel interfaces for link parameter words and pose words.
`timescale 1ns / 1ps
`default_nettype none
interface dhfk_link_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] joint_angle;
    logic signed [15:0] twist_angle;
    logic signed [31:0] link_length;
    logic signed [31:0] link_offset;
    logic               first_link;
    modport source(output valid, joint_angle, twist_angle, link_length, link_offset,
                   first_link, input ready);
    modport sink(input valid, joint_angle, twist_angle, link_length, link_offset,
                 first_link, output ready);
endinterface

interface dhfk_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source(output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
    modport sink(input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

/* sv/dhfk_cordic.sv */
// Iterative CORDIC unit giving sine and cosine, one rotation step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dhfk_cordic
    import dhfk_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [ANGLE_BITS-1:0]  angle,
    output logic                               done,
    output data32_t                            sin_val,
    output data32_t                            cos_val
);

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic signed [33:0] ph, xs, ys, xf, yf, xc, yc, xr, yr;

    always_comb
    begin
        ph = {{2{angle[ANGLE_BITS-1]}}, angle, {(32-ANGLE_BITS){1'b0}}};
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        xs = y_reg >>> i_reg;
        ys = x_reg >>> i_reg;
        if (start)
        begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            i_next = '0;
            busy_next = 1'b1;
            neg_next = 1'b0;
            z_next = ph;
            if (ph > ONE_Q30)
            begin
                z_next = ph - (ONE_Q30 <<< 1);
                neg_next = 1'b1;
            end
            else if (ph < -ONE_Q30)
            begin
                z_next = ph + (ONE_Q30 <<< 1);
                neg_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - xs;
                y_next = y_reg + ys;
                z_next = z_reg - atan_turn(i_reg);
            end
            else
            begin
                x_next = x_reg + xs;
                y_next = y_reg - ys;
                z_next = z_reg + atan_turn(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        xc = (xf > ONE_Q30) ? ONE_Q30 : ((xf < -ONE_Q30) ? -ONE_Q30 : xf);
        yc = (yf > ONE_Q30) ? ONE_Q30 : ((yf < -ONE_Q30) ? -ONE_Q30 : yf);
        xr = (xc + 34'sd1) >>> (30 - ROT_FRAC_BITS);
        yr = (yc + 34'sd1) >>> (30 - ROT_FRAC_BITS);
    end

    assign done = done_reg;
    assign cos_val = xr[31:0];
    assign sin_val = yr[31:0];

    property p_done_ends_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg;
    endproperty
    assert property (p_done_ends_busy) else $error("cordic done while busy");

    property p_step_bound;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> i_reg < 5'(CORDIC_STEPS);
    endproperty
    assert property (p_step_bound) else $error("cordic step count overrun");

    property p_done_after_last;
        @(posedge clk) disable iff (!rst_n)
            (busy_reg && !start && i_reg == 5'(CORDIC_STEPS - 1)) |=> done_reg;
    endproperty
    assert property (p_done_after_last) else $error("cordic missed done");

endmodule
`default_nettype wire

/* sv/dhfk_mac.sv */
// Shared multiply-accumulate unit with a registered product stage.
`timescale 1ns / 1ps
`default_nettype none
module dhfk_mac
    import dhfk_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     op_valid,
    input  wire mac_ctl_t                 op_ctl,
    input  wire data32_t                  opa,
    input  wire data32_t                  opb,
    input  wire data32_t                  init,
    output logic                          res_valid,
    output mac_ctl_t                      res_ctl,
    output logic signed [ACC_W-1:0]       res_acc
);

    logic signed [63:0]      prod_reg;
    mac_ctl_t                ctl_reg, rctl_reg;
    data32_t                 init_reg;
    logic                    v1_reg, v2_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next, base, term;
    logic signed [63:0]      prod_rnd;

    always_comb
    begin
        prod_rnd = (prod_reg + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
        term = ctl_reg.rnd ? ACC_W'(prod_rnd) : ACC_W'(prod_reg);
        base = ctl_reg.start ? ACC_W'(init_reg) : acc_reg;
        acc_next = v1_reg ? base + term : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= op_valid;
            v2_reg <= v1_reg && ctl_reg.last;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        ctl_reg <= op_ctl;
        init_reg <= init;
        rctl_reg <= ctl_reg;
    end

    assign res_valid = v2_reg;
    assign res_ctl = rctl_reg;
    assign res_acc = acc_reg;

    property p_res_follows_op;
        @(posedge clk) disable iff (!rst_n) res_valid |-> $past(op_valid, 2);
    endproperty
    assert property (p_res_follows_op) else $error("mac result without operation");

    property p_res_is_last;
        @(posedge clk) disable iff (!rst_n) res_valid |-> res_ctl.last;
    endproperty
    assert property (p_res_is_last) else $error("mac result not closing a group");

    property p_hold_acc;
        @(posedge clk) disable iff (!rst_n) !$past(v1_reg) |-> $stable(acc_reg);
    endproperty
    assert property (p_hold_acc) else $error("mac accumulator moved while idle");

endmodule
`default_nettype wire

/* sv/dh_forward_kinematics_chain.sv */
// Top level: sequencer, link and pose registers of the DH kinematics chain.
// Each accepted link word runs through two 28-step CORDIC passes, six link
// products, 36 chain products on one shared multiply-accumulate unit and two
// pipe drains before its pose word is valid.
// One link word in work: no new link word is taken until the last pose word is accepted.
// Reset: rst_n is asynchronous, active low; the chain accumulator is set to identity.
`timescale 1ns / 1ps
`default_nettype none
module dh_forward_kinematics_chain
    import dhfk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dhfk_link_if.sink   link_in,
    dhfk_pose_if.source pose_out
);

    seq_state_t state_reg, state_next;
    logic [2:0] lk_reg, lk_next;
    logic [1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next, drn_reg, drn_next;
    data32_t    rot_acc_reg [9];
    data32_t    pos_acc_reg [3];
    data32_t    nr_reg [9];
    data32_t    nt_reg [3];
    data32_t    lr_reg [9];
    data32_t    lt_reg [3];
    data32_t    alen_reg;
    logic signed [15:0] alpha_reg;

    logic       cs_start, cs_done;
    logic signed [ANGLE_BITS-1:0] cs_angle;
    data32_t    cs_sin, cs_cos;
    logic       op_valid, res_valid;
    mac_ctl_t   op_ctl, res_ctl;
    data32_t    opa, opb, init;
    logic signed [ACC_W-1:0] res_acc, res_rnd;
    logic [3:0] ri, li;
    logic       accept;

    assign accept = link_in.valid && link_in.ready;
    assign link_in.ready = (state_reg == S_IDLE);

    dhfk_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cs_start), .angle(cs_angle),
        .done(cs_done), .sin_val(cs_sin), .cos_val(cs_cos)
    );

    dhfk_mac u_mac (
        .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_ctl(op_ctl),
        .opa(opa), .opb(opb), .init(init),
        .res_valid(res_valid), .res_ctl(res_ctl), .res_acc(res_acc)
    );

    always_comb
    begin
        state_next = state_reg;
        lk_next = lk_reg;
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        drn_next = drn_reg;
        cs_start = 1'b0;
        cs_angle = link_in.joint_angle;
        op_valid = 1'b0;
        op_ctl = '{start: 1'b1, last: 1'b1, rnd: 1'b1, kind: DST_LR, idx: 4'd0};
        opa = lr_reg[3];
        opb = lr_reg[8];
        init = '0;
        ri = 4'({2'b0, r_reg} * 4'd3 + {2'b0, k_reg});
        li = 4'({2'b0, k_reg} * 4'd3 + {2'b0, c_reg});
        unique case (state_reg)
            S_IDLE:
            begin
                if (link_in.valid)
                begin
                    cs_start = 1'b1;
                    state_next = S_SC_T;
                end
            end
            S_SC_T:
            begin
                cs_angle = alpha_reg;
                if (cs_done)
                begin
                    cs_start = 1'b1;
                    state_next = S_SC_A;
                end
            end
            S_SC_A:
            begin
                if (cs_done)
                begin
                    lk_next = '0;
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                op_valid = 1'b1;
                unique case (lk_reg)
                    3'd0:
                    begin
                        opa = lr_reg[3]; opb = lr_reg[8];
                        op_ctl.kind = DST_LRN; op_ctl.idx = 4'd1;
                    end
                    3'd1:
                    begin
                        opa = lr_reg[3]; opb = lr_reg[7];
                        op_ctl.kind = DST_LR; op_ctl.idx = 4'd2;
                    end
                    3'd2:
                    begin
                        opa = lr_reg[0]; opb = lr_reg[8];
                        op_ctl.kind = DST_LR; op_ctl.idx = 4'd4;
                    end
                    3'd3:
                    begin
                        opa = lr_reg[0]; opb = lr_reg[7];
                        op_ctl.kind = DST_LRN; op_ctl.idx = 4'd5;
                    end
                    3'd4:
                    begin
                        opa = alen_reg; opb = lr_reg[0];
                        op_ctl.kind = DST_LT; op_ctl.idx = 4'd0;
                    end
                    default:
                    begin
                        opa = alen_reg; opb = lr_reg[3];
                        op_ctl.kind = DST_LT; op_ctl.idx = 4'd1;
                    end
                endcase
                lk_next = lk_reg + 3'd1;
                if (lk_reg == 3'd5)
                begin
                    drn_next = '0;
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1:
            begin
                drn_next = drn_reg + 2'd1;
                if (drn_reg == 2'd2)
                begin
                    r_next = '0;
                    c_next = '0;
                    k_next = '0;
                    state_next = S_MAT;
                end
            end
            S_MAT:
            begin
                op_valid = 1'b1;
                opa = rot_acc_reg[ri];
                op_ctl.start = (k_reg == 2'd0);
                op_ctl.last = (k_reg == 2'd2);
                if (c_reg == 2'd3)
                begin
                    opb = lt_reg[k_reg];
                    init = pos_acc_reg[r_reg];
                    op_ctl.rnd = 1'b1;
                    op_ctl.kind = DST_TRN;
                    op_ctl.idx = {2'b0, r_reg};
                end
                else
                begin
                    opb = lr_reg[li];
                    op_ctl.rnd = 1'b0;
                    op_ctl.kind = DST_ROT;
                    op_ctl.idx = 4'({2'b0, r_reg} * 4'd3 + {2'b0, c_reg});
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    c_next = c_reg + 2'd1;
                    if (c_reg == 2'd3)
                    begin
                        r_next = r_reg + 2'd1;
                        if (r_reg == 2'd2)
                        begin
                            drn_next = '0;
                            state_next = S_DRAIN2;
                        end
                    end
                end
            end
            S_DRAIN2:
            begin
                drn_next = drn_reg + 2'd1;
                if (drn_reg == 2'd2)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (pose_out.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lk_reg <= '0;
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
            drn_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lk_reg <= lk_next;
            r_reg <= r_next;
            c_reg <= c_next;
            k_reg <= k_next;
            drn_reg <= drn_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                rot_acc_reg[i] <= (i % 4 == 0) ? ONE_ROT : '0;
            for (int i = 0; i < 3; i++)
                pos_acc_reg[i] <= '0;
        end
        else if (accept && link_in.first_link)
        begin
            for (int i = 0; i < 9; i++)
                rot_acc_reg[i] <= (i % 4 == 0) ? ONE_ROT : '0;
            for (int i = 0; i < 3; i++)
                pos_acc_reg[i] <= '0;
        end
        else if (state_reg == S_DRAIN2 && drn_reg == 2'd2)
        begin
            for (int i = 0; i < 9; i++)
                rot_acc_reg[i] <= nr_reg[i];
            for (int i = 0; i < 3; i++)
                pos_acc_reg[i] <= nt_reg[i];
        end
    end

    assign res_rnd = (res_acc + (ACC_W'(1) <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            alen_reg <= link_in.link_length;
            alpha_reg <= link_in.twist_angle;
            lt_reg[2] <= link_in.link_offset;
            lr_reg[6] <= '0;
        end
        if (cs_done && state_reg == S_SC_T)
        begin
            lr_reg[0] <= cs_cos;
            lr_reg[3] <= cs_sin;
        end
        if (cs_done && state_reg == S_SC_A)
        begin
            lr_reg[7] <= cs_sin;
            lr_reg[8] <= cs_cos;
        end
        if (res_valid)
        begin
            unique case (res_ctl.kind)
                DST_LR:  lr_reg[res_ctl.idx] <= res_acc[31:0];
                DST_LRN: lr_reg[res_ctl.idx] <= -res_acc[31:0];
                DST_LT:  lt_reg[res_ctl.idx[1:0]] <= sat32(res_acc);
                DST_ROT: nr_reg[res_ctl.idx] <= sat32(res_rnd);
                DST_TRN: nt_reg[res_ctl.idx[1:0]] <= sat32(res_acc);
                default: ;
            endcase
        end
    end

    assign pose_out.valid  = (state_reg == S_OUT);
    assign pose_out.rot_00 = nr_reg[0];
    assign pose_out.rot_01 = nr_reg[1];
    assign pose_out.rot_02 = nr_reg[2];
    assign pose_out.rot_10 = nr_reg[3];
    assign pose_out.rot_11 = nr_reg[4];
    assign pose_out.rot_12 = nr_reg[5];
    assign pose_out.rot_20 = nr_reg[6];
    assign pose_out.rot_21 = nr_reg[7];
    assign pose_out.rot_22 = nr_reg[8];
    assign pose_out.pos_x  = nt_reg[0];
    assign pose_out.pos_y  = nt_reg[1];
    assign pose_out.pos_z  = nt_reg[2];

    property p_ready_excludes_valid;
        @(posedge clk) disable iff (!rst_n) link_in.ready |-> !pose_out.valid;
    endproperty
    assert property (p_ready_excludes_valid) else $error("input open while pose waits");

    property p_mac_results_in_window;
        @(posedge clk) disable iff (!rst_n)
            res_valid |-> (state_reg == S_LINK || state_reg == S_DRAIN1 ||
                           state_reg == S_MAT || state_reg == S_DRAIN2);
    endproperty
    assert property (p_mac_results_in_window) else $error("mac result outside window");

    property p_cordic_in_window;
        @(posedge clk) disable iff (!rst_n)
            cs_done |-> (state_reg == S_SC_T || state_reg == S_SC_A);
    endproperty
    assert property (p_cordic_in_window) else $error("cordic done outside window");

endmodule
`default_nettype wire

/* dv/tb_dhfk_if.sv */
// Testbench word types for the link and pose channels.
`timescale 1ns / 1ps
package tb_dhfk_types;
    typedef struct {
        logic signed [15:0] theta;
        logic signed [15:0] alpha;
        logic signed [31:0] len;
        logic signed [31:0] off;
        logic               first;
    } link_word_t;

    typedef struct {
        logic signed [31:0] rot [9];
        logic signed [31:0] pos [3];
    } pose_word_t;
endpackage

/* dv/tb_top.sv */
// Testbench top: drives link words into the DH chain and checks each pose word.
`timescale 1ns / 1ps
module tb_top;
    import dhfk_pkg::*;
    import tb_dhfk_types::*;

    localparam int CORDIC_N = 28;
    localparam longint LIMIT_CYCLES = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int errors = 0;
    int out_wait = 0;
    longint cycle_count = 0;
    pose_word_t expected_poses [$];
    logic signed [31:0] chain_rot [9];
    logic signed [31:0] chain_pos [3];

    dhfk_link_if link_ch();
    dhfk_pose_if pose_ch();

    dh_forward_kinematics_chain i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .link_in(link_ch.sink),
        .pose_out(pose_ch.source)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint turn_atan(int i);
        longint tbl [28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5};
        return tbl[i];
    endfunction

    task automatic angle_sin_cos(input logic [15:0] ang, output longint s, output longint c);
        logic signed [31:0] phase;
        longint z;
        longint x;
        longint y;
        longint t;
        bit flip;
        phase = {ang, 16'h0};
        z = longint'(phase);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824)
        begin
            z -= 64'sd2147483648;
            flip = 1;
        end
        else if (z < -64'sd1073741824)
        begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= turn_atan(i);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += turn_atan(i);
            end
            x = t;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        if (x > 64'sd1073741824) x = 64'sd1073741824;
        if (x < -64'sd1073741824) x = -64'sd1073741824;
        if (y > 64'sd1073741824) y = 64'sd1073741824;
        if (y < -64'sd1073741824) y = -64'sd1073741824;
        c = rnd_shift(x, 1);
        s = rnd_shift(y, 1);
    endtask

    task automatic reset_chain();
        for (int i = 0; i < 9; i++)
            chain_rot[i] = (i % 4 == 0) ? (32'sd1 <<< 29) : 32'sd0;
        for (int i = 0; i < 3; i++)
            chain_pos[i] = 0;
    endtask

    task automatic post_expected(input pose_word_t p);
        expected_poses = {expected_poses, p};
    endtask

    task automatic predict_pose(input link_word_t w);
        longint st;
        longint ct;
        longint sa;
        longint ca;
        longint lr [9];
        longint lt [3];
        longint acc;
        pose_word_t p;
        if (w.first)
            reset_chain();
        angle_sin_cos(w.theta, st, ct);
        angle_sin_cos(w.alpha, sa, ca);
        lr[0] = ct;
        lr[1] = -rnd_shift(st * ca, 29);
        lr[2] = rnd_shift(st * sa, 29);
        lr[3] = st;
        lr[4] = rnd_shift(ct * ca, 29);
        lr[5] = -rnd_shift(ct * sa, 29);
        lr[6] = 0;
        lr[7] = sa;
        lr[8] = ca;
        lt[0] = clamp32(rnd_shift(longint'(w.len) * ct, 29));
        lt[1] = clamp32(rnd_shift(longint'(w.len) * st, 29));
        lt[2] = longint'(w.off);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += longint'(chain_rot[r * 3 + k]) * lr[k * 3 + c];
                p.rot[r * 3 + c] = clamp32(rnd_shift(acc, 29));
            end
            acc = longint'(chain_pos[r]);
            for (int k = 0; k < 3; k++)
                acc += rnd_shift(longint'(chain_rot[r * 3 + k]) * lt[k], 29);
            p.pos[r] = clamp32(acc);
        end
        chain_rot = p.rot;
        chain_pos = p.pos;
        post_expected(p);
    endtask

    task automatic send_link(input link_word_t w);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            link_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        link_ch.valid <= 1'b1;
        link_ch.joint_angle <= w.theta;
        link_ch.twist_angle <= w.alpha;
        link_ch.link_length <= w.len;
        link_ch.link_offset <= w.off;
        link_ch.first_link <= w.first;
        @(posedge clk);
        while (!link_ch.ready)
            @(posedge clk);
        predict_pose(w);
    endtask

    task automatic check_pose();
        logic signed [31:0] got [12];
        pose_word_t e;
        got = '{pose_ch.rot_00, pose_ch.rot_01, pose_ch.rot_02, pose_ch.rot_10,
                pose_ch.rot_11, pose_ch.rot_12, pose_ch.rot_20, pose_ch.rot_21,
                pose_ch.rot_22, pose_ch.pos_x, pose_ch.pos_y, pose_ch.pos_z};
        if (expected_poses.size() == 0)
        begin
            $display("%0t: unexpected pose word", $time);
            errors++;
            return;
        end
        e = expected_poses.pop_front();
        for (int i = 0; i < 12; i++)
        begin
            if (got[i] !== ((i < 9) ? e.rot[i] : e.pos[i - 9]))
            begin
                $display("%0t: field %0d expected %0d actual %0d", $time, i,
                         (i < 9) ? e.rot[i] : e.pos[i - 9], got[i]);
                errors++;
            end
        end
    endtask

    always
    begin
        @(posedge clk);
        if (rst_n)
        begin
            if (pose_ch.valid && pose_ch.ready)
            begin
                check_pose();
                out_wait = $urandom_range(0, 19);
                if (out_wait != 0)
                    pose_ch.ready <= 1'b0;
            end
            else if (!pose_ch.ready)
            begin
                if (out_wait != 0)
                    out_wait--;
                if (out_wait == 0)
                    pose_ch.ready <= 1'b1;
            end
        end
    end

    function automatic link_word_t mk(int th, int al, int a, int d, bit f);
        link_word_t w;
        w.theta = 16'(th);
        w.alpha = 16'(al);
        w.len = a;
        w.off = d;
        w.first = f;
        return w;
    endfunction

    function automatic link_word_t rand_link(bit f, bit wild);
        link_word_t w;
        w.theta = 16'($urandom);
        w.alpha = 16'($urandom);
        w.first = f;
        if (wild)
        begin
            w.len = $urandom;
            w.off = $urandom;
        end
        else
        begin
            w.len = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            w.off = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        end
        return w;
    endfunction

    task automatic wait_drained();
        link_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_poses.size() != 0);
    endtask

    task automatic test_extremes();
        send_link(mk(0, 0, 0, 0, 1'b0));
        send_link(mk(16384, 0, 32'sh00010000, 0, 1'b1));
        send_link(mk(-32768, 16384, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
        send_link(mk(32767, -16384, 32'sh80000000, 32'sh80000000, 1'b0));
        send_link(mk(-16384, -32768, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
        send_link(mk(16385, 16383, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
        send_link(mk(-16385, -16383, -1, 1, 1'b0));
        send_link(mk(8192, 8192, 32'sh00020000, 32'sh00010000, 1'b1));
        send_link(mk(-32767, 32767, 32'sh40000000, -32'sh40000000, 1'b0));
        send_link(mk(1, -1, 32'sh80000000, 32'sh7fffffff, 1'b1));
    endtask

    task automatic test_pause();
        send_link(rand_link(1'b1, 1'b0));
        send_link(rand_link(1'b0, 1'b0));
        wait_drained();
        send_link(rand_link(1'b0, 1'b1));
    endtask

    task automatic test_random_arms();
        int arm_len;
        int sent;
        sent = 0;
        while (sent < 1240)
        begin
            arm_len = $urandom_range(1, 8);
            for (int j = 0; j < arm_len; j++)
            begin
                send_link(rand_link(j == 0 ? 1'b1 : ($urandom_range(0, 15) == 0),
                                    $urandom_range(0, 9) == 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        link_ch.valid = 1'b0;
        link_ch.joint_angle = '0;
        link_ch.twist_angle = '0;
        link_ch.link_length = '0;
        link_ch.link_offset = '0;
        link_ch.first_link = 1'b0;
        pose_ch.ready = 1'b0;
        reset_chain();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_pause();
        test_random_arms();
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
sv/dhfk_pkg.sv
sv/dhfk_if.sv
sv/dhfk_cordic.sv
sv/dhfk_mac.sv
sv/dh_forward_kinematics_chain.sv
dv/tb_dhfk_if.sv
dv/tb_top.sv
